### rtl/core/ccss_pkg.sv
// Package for the capacity capped share split unit.
// Holds widths, register indexes and the sequencer state type; no dependencies.
package ccss_pkg;

   localparam int MAX_RANKS   = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int NUM_W       = 7;
   localparam int RANK_W      = 6;
   localparam int CNT_W       = $clog2(MAX_RANKS + 1);
   localparam int IDX_W       = $clog2(MAX_RANKS);
   localparam int SUM_W       = COUNT_WIDTH + NUM_W;
   localparam int STEP_W      = $clog2(COUNT_WIDTH);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOTAL   = 2'd0,
      CSR_NRANKS  = 2'd1,
      CSR_MY_RANK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DEF,
      ST_WALK_RD,
      ST_WALK_ACC,
      ST_DONE
   } state_type;

endpackage

### rtl/core/ccss_if.sv
// Stream channel interfaces for the capacity capped share split unit.
// Request carries one rank's free space, response one count; uses ccss_pkg widths.
interface ccss_req_if import ccss_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] space_left;
   logic                   last;

   modport source (output valid, output space_left, output last, input ready);
   modport sink   (input valid, input space_left, input last, output ready);
endinterface

interface ccss_rsp_if import ccss_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] local_count;

   modport source (output valid, output local_count, input ready);
   modport sink   (input valid, input local_count, output ready);
endinterface

### rtl/core/capacity_capped_share_split_unit.sv
// Capacity capped share split: per-rank free space store, bit-serial divider and
// a rank walker that caps even shares and hands out the shortfall.
// Depends on ccss_pkg and the ccss_req_if / ccss_rsp_if interfaces.
// A beat without last is taken while loading; after a last beat the result appears
// after COUNT_WIDTH divide steps, a capping pass over the n ranks and a shortfall walk
// over ranks 0 to my_rank, read through the single memory read port. No new beat is
// taken until the result is in the response register. Reset (synchronous, active
// high) clears the sequencer, rank count and response valid and resets the config.
module capacity_capped_share_split_unit import ccss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ccss_req_if.sink              req_chan,
   ccss_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] total_ff;
   logic [NUM_W-1:0]       nranks_ff;
   logic [RANK_W-1:0]      my_rank_ff;

   logic [COUNT_WIDTH-1:0] space_mem [MAX_RANKS];
   logic [COUNT_WIDTH-1:0] rd_ff;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0]       n_ff, n_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [COUNT_WIDTH-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] def_ff, def_in;
   logic [COUNT_WIDTH-1:0] result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                   req_beat;
   logic                   slot_free;
   logic [NUM_W-1:0]       n_sat;
   logic [NUM_W:0]         div_tmp;
   logic                   div_ge;
   logic [NUM_W:0]         div_diff;
   logic [COUNT_WIDTH-1:0] ideal;
   logic [COUNT_WIDTH-1:0] cap;
   logic [COUNT_WIDTH-1:0] share;
   logic [COUNT_WIDTH-1:0] room;
   logic [COUNT_WIDTH-1:0] give;
   logic                   is_last_rank;

   assign req_beat  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      priority if (nranks_ff == '0) begin
         n_sat = NUM_W'(1);
      end else if (nranks_ff > NUM_W'(MAX_RANKS)) begin
         n_sat = NUM_W'(MAX_RANKS);
      end else begin
         n_sat = nranks_ff;
      end
   end

   // shared divider step and per-rank cap unit
   assign div_tmp  = {rem_ff, quo_ff[COUNT_WIDTH-1]};
   assign div_ge   = div_tmp >= {1'b0, n_ff};
   assign div_diff = div_tmp - {1'b0, n_ff};

   assign ideal = quo_ff + COUNT_WIDTH'({1'b0, idx_ff} < rem_ff);
   assign cap   = (CNT_W'(idx_ff) < cnt_ff) ? rd_ff : '0;
   assign share = (ideal < cap) ? ideal : cap;
   assign room  = cap - share;
   assign give  = (room < def_ff) ? room : def_ff;
   assign is_last_rank = ({1'b0, idx_ff} == (n_ff - NUM_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         nranks_ff  <= NUM_W'(1);
         my_rank_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_TOTAL:   total_ff   <= csr_wdata[COUNT_WIDTH-1:0];
            CSR_NRANKS:  nranks_ff  <= csr_wdata[NUM_W-1:0];
            CSR_MY_RANK: my_rank_ff <= csr_wdata[RANK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && (cnt_ff < CNT_W'(MAX_RANKS))) begin
         space_mem[cnt_ff[IDX_W-1:0]] <= req_chan.space_left;
      end
      rd_ff <= space_mem[idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (req_beat && req_chan.last) state_in = ST_DIV;
         ST_DIV:      if (step_ff == STEP_W'(COUNT_WIDTH - 1)) state_in = ST_SUM_RD;
         ST_SUM_RD:   state_in = ST_SUM_ACC;
         ST_SUM_ACC:  state_in = is_last_rank ? ST_DEF : ST_SUM_RD;
         ST_DEF:      state_in = ({1'b0, my_rank_ff} >= n_ff) ? ST_DONE : ST_WALK_RD;
         ST_WALK_RD:  state_in = ST_WALK_ACC;
         ST_WALK_ACC: if (idx_ff == my_rank_ff) state_in = ST_DONE;
                      else state_in = ST_WALK_RD;
         ST_DONE:     if (slot_free) state_in = ST_LOAD;
         default:     state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      sum_in       = sum_ff;
      def_in       = def_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat && (cnt_ff < CNT_W'(MAX_RANKS))) cnt_in = cnt_ff + CNT_W'(1);
            n_in    = n_sat;
            quo_in  = total_ff;
            rem_in  = '0;
            step_in = '0;
            sum_in  = '0;
            idx_in  = '0;
         end
         ST_DIV: begin
            quo_in  = {quo_ff[COUNT_WIDTH-2:0], div_ge};
            rem_in  = div_ge ? div_diff[NUM_W-1:0] : div_tmp[NUM_W-1:0];
            step_in = step_ff + STEP_W'(1);
         end
         ST_SUM_RD: ;
         ST_SUM_ACC: begin
            sum_in = sum_ff + SUM_W'(share);
            idx_in = is_last_rank ? '0 : idx_ff + IDX_W'(1);
         end
         ST_DEF: begin
            def_in    = total_ff - sum_ff[COUNT_WIDTH-1:0];
            result_in = '0;
            idx_in    = '0;
         end
         ST_WALK_RD: ;
         ST_WALK_ACC: begin
            result_in = share + give;
            def_in    = def_ff - give;
            if (idx_ff != my_rank_ff) idx_in = idx_ff + IDX_W'(1);
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               cnt_in       = '0;
               sum_in       = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      def_ff      <= def_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      req_chan.ready       = (state_ff == ST_LOAD);
      rsp_chan.valid       = rsp_valid_ff;
      rsp_chan.local_count = rsp_data_ff;
   end

endmodule

### rtl/core/ccss_checker.sv
// Port-level checks for capacity_capped_share_split_unit, attached by bind.
// Depends on ccss_pkg for widths.
module ccss_checker import ccss_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_last,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COUNT_WIDTH-1:0] rsp_local_count
);

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("request side ready right after a last beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_local_count)))
      else $error("stalled response beat dropped or changed");

   a_rsp_from_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a finished split");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind capacity_capped_share_split_unit ccss_checker u_ccss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_last        (req_chan.last),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_local_count (rsp_chan.local_count)
);

### verif/testbench.sv
// Self-checking testbench for capacity_capped_share_split_unit: streams per-rank free space
// sets, predicts each reported count with a capped even split plus a shortfall walk.
// Depends on ccss_pkg and the ccss_req_if / ccss_rsp_if interfaces.
module testbench;
   import ccss_pkg::*;

   localparam int SETTLE_CYCLES = 320;
   localparam int STALL_LIMIT   = 4000;
   localparam int ITEM_TARGET   = 1250;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ccss_req_if req_if ();
   ccss_rsp_if rsp_if ();

   capacity_capped_share_split_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   logic [COUNT_WIDTH-1:0] cfg_total   = '0;
   logic [NUM_W-1:0]       cfg_ranks   = NUM_W'(1);
   logic [RANK_W-1:0]      cfg_my_rank = '0;
   logic [COUNT_WIDTH-1:0] space_mem [MAX_RANKS];
   int                     loaded_ranks = 0;
   logic [COUNT_WIDTH-1:0] expected_counts [$];

   int          fail_count     = 0;
   int          counted_items  = 0;
   int          idle_cycles    = 0;
   int          burst_left     = 0;
   bit          sender_gaps_on = 1'b1;
   logic [15:0] ready_pattern  = 16'hFFFF;
   logic [3:0]  ready_phase    = '0;
   logic [COUNT_WIDTH-1:0] want_count;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [COUNT_WIDTH-1:0] split_local_count();
      logic [63:0] caps   [MAX_RANKS];
      logic [63:0] shares [MAX_RANKS];
      logic [63:0] total, nn, base, rem, ideal, sum, deficit, room, give;
      int n;
      total = 64'(cfg_total);
      n = cfg_ranks;
      if (n < 1) n = 1;
      if (n > MAX_RANKS) n = MAX_RANKS;
      nn = 64'(n);
      base = total / nn;
      rem = total % nn;
      sum = '0;
      for (int r = 0; r < n; r++) begin
         ideal = base + ((64'(r) < rem) ? 64'd1 : 64'd0);
         caps[r] = (r < loaded_ranks) ? 64'(space_mem[r]) : 64'd0;
         shares[r] = (ideal < caps[r]) ? ideal : caps[r];
         sum += shares[r];
      end
      deficit = total - sum;
      for (int r = 0; r < n && deficit > 0; r++) begin
         room = caps[r] - shares[r];
         give = (room < deficit) ? room : deficit;
         shares[r] += give;
         deficit -= give;
      end
      if (int'(cfg_my_rank) >= n) return '0;
      return shares[cfg_my_rank][COUNT_WIDTH-1:0];
   endfunction

   function automatic void load_space_beat(input logic [COUNT_WIDTH-1:0] space,
                                           input logic last);
      if (loaded_ranks < MAX_RANKS) begin
         space_mem[loaded_ranks] = space;
         loaded_ranks++;
         counted_items++;
      end
      if (last) begin
         expected_counts.push_back(split_local_count());
         loaded_ranks = 0;
      end
   endfunction

   task automatic send_beat(input logic [COUNT_WIDTH-1:0] space, input logic last);
      int gap;
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.space_left <= space;
      req_if.last       <= last;
      do @(posedge clock); while (!req_if.ready);
      load_space_beat(space, last);
   endtask

   function automatic logic [COUNT_WIDTH-1:0] pick_space(input logic [COUNT_WIDTH-1:0] share);
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3:       return share + COUNT_WIDTH'($urandom_range(0, 2)) - 1;
         4:       return share >> 1;
         5:       return COUNT_WIDTH'($urandom_range(0, 15));
         default: return share + COUNT_WIDTH'($urandom_range(0, 1000));
      endcase
   endfunction

   task automatic send_set(input int beats, input logic [COUNT_WIDTH-1:0] share);
      for (int i = 0; i < beats; i++) send_beat(pick_space(share), i == beats - 1);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TOTAL:   cfg_total   = data[COUNT_WIDTH-1:0];
         CSR_NRANKS:  cfg_ranks   = data[NUM_W-1:0];
         CSR_MY_RANK: cfg_my_rank = data[RANK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] total, input logic [31:0] ranks,
                            input logic [31:0] mine);
      write_csr(CSR_TOTAL, total);
      write_csr(CSR_NRANKS, ranks);
      write_csr(CSR_MY_RANK, mine);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_pattern();
      case ($urandom_range(0, 3))
         0:       return 16'hFFFF;
         1:       return 16'($urandom) | (16'd1 << $urandom_range(0, 15));
         2:       return 16'($urandom & $urandom) | (16'd1 << $urandom_range(0, 15));
         default: return 16'hFFFF ^ (16'd1 << $urandom_range(0, 15));
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_beat($urandom, 1'b0);
      send_beat('1, 1'b1);
      finish_phase();
   endtask

   task automatic test_zero_total();
      configure(32'd0, 32'd4, 32'd1);
      send_beat('1, 1'b0);
      send_beat('0, 1'b0);
      send_beat(32'd5, 1'b0);
      send_beat(32'd7, 1'b1);
      finish_phase();
   endtask

   task automatic test_shortfall_dropped();
      configure(32'd1000, 32'd3, 32'd2);
      send_beat(32'd10, 1'b0);
      send_beat(32'd20, 1'b0);
      send_beat(32'd30, 1'b1);
      finish_phase();
   endtask

   task automatic test_rank_saturation();
      configure('1, 32'hFFFF_FF80, 32'd0);
      send_beat('1, 1'b1);
      finish_phase();
      configure('1, 32'd127, 32'd1);
      send_beat('1, 1'b0);
      send_beat(32'h8000_0001, 1'b1);
      finish_phase();
      configure('1, 32'd127, 32'd63);
      send_beat(32'h7FFF_FFFF, 1'b0);
      send_beat('1, 1'b1);
      finish_phase();
   endtask

   task automatic test_rank_out_of_range();
      configure(32'd77, 32'd2, 32'hFFFF_FFC5);
      send_beat(32'd50, 1'b0);
      send_beat(32'd50, 1'b1);
      finish_phase();
   endtask

   task automatic test_shortfall_walk();
      configure(32'd100, 32'd4, 32'd3);
      send_beat(32'd5, 1'b0);
      send_beat(32'd100, 1'b0);
      send_beat(32'd0, 1'b0);
      send_beat(32'd100, 1'b1);
      finish_phase();
      configure(32'd100, 32'd4, 32'd1);
      send_beat(32'd5, 1'b0);
      send_beat(32'd100, 1'b0);
      send_beat(32'd0, 1'b0);
      send_beat(32'd100, 1'b1);
      finish_phase();
   endtask

   task automatic test_overflow_sets();
      configure('1, 32'd64, 32'd63);
      send_set(70, 32'h0400_0000);
      send_set(65, 32'h0400_0000);
      finish_phase();
   endtask

   task automatic test_random_sets();
      logic [NUM_W-1:0]  ranks;
      logic [RANK_W-1:0] mine;
      logic [31:0]       total, ranks_word, mine_word;
      int n_eff, beats;
      while (counted_items < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       ranks = NUM_W'(1);
            1:       ranks = NUM_W'(64);
            2:       ranks = '0;
            3:       ranks = NUM_W'($urandom_range(65, 127));
            4:       ranks = NUM_W'($urandom_range(17, 64));
            default: ranks = NUM_W'($urandom_range(1, 16));
         endcase
         n_eff = (ranks == 0) ? 1 : (ranks > MAX_RANKS) ? MAX_RANKS : int'(ranks);
         if ($urandom_range(0, 3) == 0) mine = RANK_W'($urandom);
         else mine = RANK_W'($urandom_range(0, n_eff - 1));
         case ($urandom_range(0, 4))
            0:       total = '0;
            1:       total = '1;
            2:       total = $urandom_range(0, 300);
            default: total = $urandom;
         endcase
         ranks_word = 32'(ranks);
         mine_word = 32'(mine);
         if ($urandom_range(0, 1)) ranks_word[31:NUM_W] = (32 - NUM_W)'($urandom);
         if ($urandom_range(0, 1)) mine_word[31:RANK_W] = (32 - RANK_W)'($urandom);
         configure(total, ranks_word, mine_word);
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         ready_pattern = pick_pattern();
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 9))
               6, 7:    beats = $urandom_range(1, n_eff);
               8:       beats = $urandom_range(1, 4);
               9: begin
                  if ($urandom_range(0, 3) == 0) beats = $urandom_range(65, 70);
                  else beats = (n_eff + 3 > MAX_RANKS) ? MAX_RANKS : n_eff + 3;
               end
               default: beats = n_eff;
            endcase
            send_set(beats, total / n_eff);
         end
         finish_phase();
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ready_pattern[ready_phase];
      ready_phase  <= ready_phase + 4'd1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: count with none pending, expected none, got %0d",
                     $time, rsp_if.local_count);
            fail_count++;
         end else begin
            want_count = expected_counts.pop_front();
            if (rsp_if.local_count !== want_count) begin
               $display("%0t: local_count mismatch, expected %0d, got %0d",
                        $time, want_count, rsp_if.local_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.space_left = '0;
      req_if.last       = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_idx           = CSR_TOTAL;
      csr_wdata         = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_total();
      test_shortfall_dropped();
      test_rank_saturation();
      test_rank_out_of_range();
      test_shortfall_walk();
      ready_pattern = pick_pattern();
      test_overflow_sets();
      test_random_sets();
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/ccss_pkg.sv
rtl/core/ccss_if.sv
rtl/core/capacity_capped_share_split_unit.sv
rtl/core/ccss_checker.sv
verif/testbench.sv
